// ----- rtl/core/lpmr_pkg.sv -----
`default_nettype none

package lpmr_pkg;

   // fixed field widths
   localparam int ADDR_W = 32;
   localparam int SLOT_W = 4;
   localparam int PORT_W = 2;

   // slots reachable through the slot field
   localparam int MAX_SLOTS = 1 << SLOT_W;

   // defaults for the top level parameters
   localparam int ROUTES_DEFAULT = 16;
   localparam int PORTS_DEFAULT  = 4;

   // function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] route_dest;
      logic [ADDR_W-1:0] route_mask;
      logic [ADDR_W-1:0] route_gateway;
      logic [PORT_W-1:0] route_port;
      logic              route_enable;
      logic [ADDR_W-1:0] lookup_addr;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] next_hop;
      logic [PORT_W-1:0] out_port;
      logic [SLOT_W-1:0] match_slot;
   } rsp_type;

   // one stored route
   typedef struct packed {
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] gateway;
      logic [PORT_W-1:0] port;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ----- rtl/core/lpmr_ram.sv -----
`default_nettype none

module lpmr_ram #(
   parameter int WIDTH = lpmr_pkg::ENTRY_W,
   parameter int DEPTH = lpmr_pkg::ROUTES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/longest_prefix_route_lookup.sv -----
`default_nettype none

// IPv4 longest-prefix-match route table. A transfer with func set to write
// stores one route (destination, mask, gateway, port, enable) in a slot in the
// cycle it is taken; busy stays low and nothing comes back. A write to a slot
// at or past the table depth, or with a port at or past PORTS, is dropped.
// A lookup transfer raises busy and walks the table one entry per cycle,
// since all entries sit in a RAM with one read port and a single mask/compare
// unit judges them in turn. busy stays high through the scan, the last compare
// and the result strobe. The table depth is ROUTES capped at the 16 slots the
// slot field can address. The result is on rsp_data in the last busy cycle, for
// exactly one cycle with rsp_valid high; the receiver cannot stall it, so it
// must take the transfer in that cycle. The longest (numerically largest)
// matching mask wins, the lowest slot wins a tie, and a mask of zero acts as a
// default route. On a miss hit is low and the other result fields are zero.
// Reset empties the table at once through per-slot valid flags.
module longest_prefix_route_lookup #(
   parameter int ROUTES = lpmr_pkg::ROUTES_DEFAULT,
   parameter int PORTS  = lpmr_pkg::PORTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lpmr_pkg::req_type req_data,
   output logic                  rsp_valid,
   output lpmr_pkg::rsp_type     rsp_data
);

   // slots beyond the reach of the slot field can never be written
   localparam int DEPTH = (ROUTES < lpmr_pkg::MAX_SLOTS) ? ROUTES : lpmr_pkg::MAX_SLOTS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a transfer
   localparam logic [1:0] ST_SCAN = 2'd1;  // issuing table reads
   localparam logic [1:0] ST_LAST = 2'd2;  // judging the final entry
   localparam logic [1:0] ST_RESP = 2'd3;  // result strobe

   logic [1:0] state_ff, state_in;

   // input side
   logic req_take;
   logic wr_take;
   logic wr_ok;
   logic lookup_take;

   // table
   logic [DEPTH-1:0]          valid_ff;
   lpmr_pkg::entry_type       wr_entry;
   logic [lpmr_pkg::ENTRY_W-1:0] rd_raw;
   lpmr_pkg::entry_type       rd_entry;

   // scan pointer and compare stage
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_go_ff;
   logic             rd_en;

   // lookup address and best match so far
   logic [lpmr_pkg::ADDR_W-1:0] addr_ff;
   logic                        found_ff;
   logic [lpmr_pkg::ADDR_W-1:0] best_mask_ff;
   logic [lpmr_pkg::ADDR_W-1:0] best_gw_ff;
   logic [lpmr_pkg::PORT_W-1:0] best_port_ff;
   logic [IDX_W-1:0]            best_idx_ff;

   logic entry_match;
   logic entry_wins;

   assign req_take    = start && !busy;
   assign wr_take     = req_take && (req_data.func == lpmr_pkg::FUNC_WRITE);
   assign lookup_take = req_take && (req_data.func == lpmr_pkg::FUNC_LOOKUP);

   // out-of-range slot or port drops the write
   assign wr_ok = (32'(req_data.slot) < 32'(DEPTH)) &&
                  (32'(req_data.route_port) < 32'(PORTS));

   assign wr_entry.dest    = req_data.route_dest;
   assign wr_entry.mask    = req_data.route_mask;
   assign wr_entry.gateway = req_data.route_gateway;
   assign wr_entry.port    = req_data.route_port;

   assign rd_en = (state_ff == ST_SCAN);

   lpmr_ram #(
      .WIDTH (lpmr_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_take && wr_ok),
      .wr_addr    (req_data.slot[IDX_W-1:0]),
      .wr_data    (wr_entry),
      .rd_en      (rd_en),
      .rd_addr    (idx_ff),
      .rd_data_ff (rd_raw)
   );

   assign rd_entry = rd_raw;

   // shared compare unit: prefix test, then strict mask compare keeps the
   // lowest slot on a tie
   assign entry_match = valid_ff[cmp_idx_ff] &&
                        (((addr_ff ^ rd_entry.dest) & rd_entry.mask) == '0);
   assign entry_wins  = cmp_go_ff && entry_match &&
                        (!found_ff || (rd_entry.mask > best_mask_ff));

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (lookup_take) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cmp_go_ff <= 1'b0;
         valid_ff  <= '0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cmp_go_ff <= rd_en;
         if (wr_take && wr_ok) begin
            valid_ff[req_data.slot[IDX_W-1:0]] <= req_data.route_enable;
         end
         if (lookup_take) begin
            found_ff <= 1'b0;
         end else if (entry_wins) begin
            found_ff <= 1'b1;
         end
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= idx_ff;
      if (lookup_take) begin
         addr_ff      <= req_data.lookup_addr;
         best_mask_ff <= '0;
         best_gw_ff   <= '0;
         best_port_ff <= '0;
         best_idx_ff  <= '0;
      end else if (entry_wins) begin
         best_mask_ff <= rd_entry.mask;
         best_gw_ff   <= rd_entry.gateway;
         best_port_ff <= rd_entry.port;
         best_idx_ff  <= cmp_idx_ff;
      end
   end

   // best registers stay zero on a miss
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = (state_ff == ST_RESP);
   assign rsp_data.hit        = found_ff;
   assign rsp_data.next_hop   = best_gw_ff;
   assign rsp_data.out_port   = best_port_ff;
   assign rsp_data.match_slot = lpmr_pkg::SLOT_W'(best_idx_ff);

   // a result strobe only ends a lookup
   a_rsp_in_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a lookup");

   // an accepted lookup holds busy
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.func == lpmr_pkg::FUNC_LOOKUP)) |=> busy)
      else $error("lookup accepted without raising busy");

   // the block frees up right after the strobe
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("busy held past the result");

   // a miss carries zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.next_hop == '0) && (rsp_data.out_port == '0) &&
         (rsp_data.match_slot == '0))
      else $error("miss result carries stale fields");

endmodule

`default_nettype wire
